[src/fca_pkg.sv]
package fca_pkg;

  // Block index width and the largest table that index can address
  localparam int BLOCK_W         = 10;
  localparam int MAX_LIVE        = 1 << BLOCK_W;
  localparam int BLOCK_COUNT_DEF = 1024;

  // Formatted image: blocks below FORMAT_USED_CNT in use, one link set
  localparam int              FORMAT_USED_CNT = 4;
  localparam int              FORMAT_LINK_BLK = 1;
  localparam logic [BLOCK_W-1:0] FORMAT_LINK_VAL = BLOCK_W'(2);
  localparam logic [BLOCK_W-1:0] FIRST_DATA_RST  = BLOCK_W'(4);

  // Operation codes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_EXTEND = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;
  localparam logic [1:0] OP_NEXT   = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;

  // Configuration address width and register index
  localparam int          CFG_AW         = 3;
  localparam logic [0:0]  REG_FIRST_DATA = 1'b0;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [BLOCK_W-1:0] block;
  } in_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] result_block;
    logic               end_of_chain;
    logic [1:0]         status;
  } out_t;

  // One table entry: in-use mark and next-block link
  typedef struct packed {
    logic               used;
    logic [BLOCK_W-1:0] link;
  } entry_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    out_t data;
  } seq_res_t;

endpackage

[src/fca_ram.sv]
module fca_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/fca_seq.sv]
module fca_seq #(
  parameter int LIVE_BLOCKS = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  fca_pkg::in_t                in_data,
  output logic                        in_stall,
  input  logic [fca_pkg::BLOCK_W-1:0] first_data_block,
  output fca_pkg::seq_res_t           res,
  input  logic                        res_ack
);
  import fca_pkg::*;

  localparam int AW = $clog2(LIVE_BLOCKS);
  localparam int CW = AW + 1;
  localparam int EW = $bits(entry_t);
  localparam logic [CW-1:0]      LIVE_C = CW'(LIVE_BLOCKS);
  localparam logic [BLOCK_W:0]   LIVE_X = (BLOCK_W + 1)'(LIVE_BLOCKS);

  // Sequencer states
  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_CHK      = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_WR_NEW   = 4'd4;
  localparam logic [3:0] S_WR_LINK  = 4'd5;
  localparam logic [3:0] S_FREE_RD  = 4'd6;
  localparam logic [3:0] S_FREE_CHK = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [BLOCK_W-1:0] blk_r, blk_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               chk_r, chk_nxt;
  logic [AW-1:0]      cur_r, cur_nxt;
  logic [AW-1:0]      nb_r, nb_nxt;
  logic               first_r, first_nxt;
  out_t               out_r, out_nxt;

  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  logic [AW-1:0]      raddr;
  logic [EW-1:0]      rdata;
  entry_t             rd_ent;

  logic [BLOCK_W:0]   start_x;
  logic               start_past;
  logic               blk_in_range;
  logic               nx_in_range;
  logic [CW-1:0]      cnt_prev;

  fca_ram #(
    .WIDTH (EW),
    .DEPTH (LIVE_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ent = entry_t'(rdata);

  // Search start: a start of zero counts as one
  assign start_x    = (first_data_block == '0) ? (BLOCK_W + 1)'(1)
                                               : {1'b0, first_data_block};
  assign start_past = start_x >= LIVE_X;

  assign blk_in_range = {1'b0, in_data.block} < LIVE_X;
  assign nx_in_range  = {1'b0, rd_ent.link} < LIVE_X;
  assign cnt_prev     = cnt_r - CW'(1);

  assign in_stall  = state_r != S_IDLE;
  assign res.valid = state_r == S_DONE;
  assign res.data  = out_r;

  // Next-state logic and table port control
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    blk_nxt   = blk_r;
    cnt_nxt   = cnt_r;
    chk_nxt   = chk_r;
    cur_nxt   = cur_r;
    nb_nxt    = nb_r;
    first_nxt = first_r;
    out_nxt   = out_r;
    we        = 1'b0;
    waddr     = cnt_r[AW-1:0];
    wdata     = '0;
    raddr     = cnt_r[AW-1:0];

    case (state_r)
      S_CLR: begin
        // Sweep the formatted image into the table
        we         = 1'b1;
        wdata.used = cnt_r < CW'(FORMAT_USED_CNT);
        wdata.link = (cnt_r == CW'(FORMAT_LINK_BLK)) ? FORMAT_LINK_VAL : '0;
        cnt_nxt    = cnt_r + CW'(1);
        if (cnt_r == LIVE_C - CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        raddr = in_data.block[AW-1:0];
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          blk_nxt   = in_data.block;
          cur_nxt   = in_data.block[AW-1:0];
          first_nxt = 1'b1;
          chk_nxt   = 1'b0;
          out_nxt   = '0;
          if (in_data.opcode == OP_ALLOC) begin
            if (start_past) begin
              out_nxt.status = ST_NO_FREE;
              state_nxt      = S_DONE;
            end else begin
              cnt_nxt   = start_x[CW-1:0];
              state_nxt = S_SCAN;
            end
          end else if (!blk_in_range) begin
            out_nxt.status = ST_NOT_USED;
            state_nxt      = S_DONE;
          end else if (in_data.opcode == OP_FREE) begin
            state_nxt = S_FREE_CHK;
          end else begin
            state_nxt = S_CHK;
          end
        end
      end

      S_CHK: begin
        // Block read for extend or next has landed
        if (!rd_ent.used) begin
          out_nxt.status = ST_NOT_USED;
          state_nxt      = S_DONE;
        end else if (op_r == OP_NEXT) begin
          out_nxt.result_block = rd_ent.link;
          out_nxt.end_of_chain = rd_ent.link == '0;
          state_nxt            = S_DONE;
        end else if (start_past) begin
          out_nxt.status = ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          cnt_nxt   = start_x[CW-1:0];
          chk_nxt   = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue one read a cycle, test the entry read the cycle before
        if (chk_r && !rd_ent.used) begin
          nb_nxt    = cnt_prev[AW-1:0];
          state_nxt = S_WR_NEW;
        end else if (cnt_r == LIVE_C) begin
          out_nxt.status = ST_NO_FREE;
          state_nxt      = S_DONE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          chk_nxt = 1'b1;
        end
      end

      S_WR_NEW: begin
        // Claim the found block as a chain end
        we                   = 1'b1;
        waddr                = nb_r;
        wdata.used           = 1'b1;
        wdata.link           = '0;
        out_nxt.result_block = BLOCK_W'(nb_r);
        state_nxt            = (op_r == OP_EXTEND) ? S_WR_LINK : S_DONE;
      end

      S_WR_LINK: begin
        // Hook the new block after the given one
        we         = 1'b1;
        waddr      = blk_r[AW-1:0];
        wdata.used = 1'b1;
        wdata.link = BLOCK_W'(nb_r);
        state_nxt  = S_DONE;
      end

      S_FREE_RD: begin
        raddr     = cur_r;
        state_nxt = S_FREE_CHK;
      end

      S_FREE_CHK: begin
        // Release one chain block, stop at an unused block or a null or out-of-range link
        first_nxt = 1'b0;
        if (!rd_ent.used) begin
          out_nxt.status = first_r ? ST_NOT_USED : ST_OK;
          state_nxt      = S_DONE;
        end else begin
          we    = 1'b1;
          waddr = cur_r;
          wdata = '0;
          if (rd_ent.link == '0 || !nx_in_range) begin
            state_nxt = S_DONE;
          end else begin
            cur_nxt   = rd_ent.link[AW-1:0];
            state_nxt = S_FREE_RD;
          end
        end
      end

      S_DONE: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      chk_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chk_r   <= chk_nxt;
      first_r <= first_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    blk_r <= blk_nxt;
    cur_r <= cur_nxt;
    nb_r  <= nb_nxt;
    out_r <= out_nxt;
  end

endmodule

[src/fat_chain_allocator_unit.sv]
// Block chain allocator: a table of min(BLOCK_COUNT, 1024) entries, each an
// in-use mark and a next-block link, held in one single-port-write RAM. After
// reset the block stalls its input while a clearing pass writes the formatted
// image (blocks 0 to 3 used, 1 linked to 2). It then takes one item at a time
// and holds in_stall until the result has moved into the output register.
// Allocate searches from the search start to the table end, reading one entry
// a cycle; extend adds a check read of the given block before the search and a
// link write after it; next is a single check read; free reads and then writes
// each block of the chain through the table port. The result register lets a
// new item enter while the previous result waits to be taken.
module fat_chain_allocator_unit #(
  parameter int BLOCK_COUNT = fca_pkg::BLOCK_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  fca_pkg::in_t                in_data,
  output logic                        in_stall,
  output logic                        out_valid,
  output fca_pkg::out_t               out_data,
  input  logic                        out_stall,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fca_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fca_pkg::*;

  localparam int LIVE_BLOCKS = (BLOCK_COUNT < MAX_LIVE) ? BLOCK_COUNT : MAX_LIVE;

  logic [BLOCK_W-1:0] first_data_r, first_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r;
  seq_res_t           res;
  logic               res_ack;
  logic               cfg_wr;
  logic               reg_sel;

  fca_seq #(
    .LIVE_BLOCKS (LIVE_BLOCKS)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_data          (in_data),
    .in_stall         (in_stall),
    .first_data_block (first_data_r),
    .res              (res),
    .res_ack          (res_ack)
  );

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = paddr[CFG_AW-1] == REG_FIRST_DATA;
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = reg_sel ? {{(32 - BLOCK_W){1'b0}}, first_data_r} : '0;

  always_comb begin
    first_data_nxt = first_data_r;
    if (cfg_wr && reg_sel) begin
      first_data_nxt = pwdata[BLOCK_W-1:0];
    end
  end

  // Load the output register when it is empty or being drained
  assign res_ack = res.valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ack) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_data_r <= FIRST_DATA_RST;
      out_valid_r  <= 1'b0;
    end else begin
      first_data_r <= first_data_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ack) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/fca_checker.sv]
module fca_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input fca_pkg::out_t              out_data,
  input logic                       out_stall
);
  import fca_pkg::*;

  // Clearing pass holds the input off straight after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  // One item at a time: a transfer in closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
      in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is at work");

  // A chain end is only reported on a successful next with a null link
  a_eoc_clean: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_data.end_of_chain |->
      out_data.result_block == '0 && out_data.status == ST_OK)
    else $error("end of chain with link or error");

  // An error result carries no block
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_data.status != ST_OK |->
      out_data.result_block == '0 && !out_data.end_of_chain)
    else $error("error result with block data");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind fat_chain_allocator_unit fca_checker u_fca_checker (.*);

[bench/tb_fat_chain_allocator_unit.sv]
module tb_fat_chain_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fca_pkg::*;

  localparam int TABLE_SIZE = (BLOCK_COUNT_DEF < MAX_LIVE) ? BLOCK_COUNT_DEF : MAX_LIVE;
  localparam logic [CFG_AW-1:0] ADDR_FIRST_DATA = CFG_AW'(4 * int'(REG_FIRST_DATA));
  localparam int MAX_IDLE = 18;
  localparam logic [BLOCK_W-1:0] LAST_BLOCK = BLOCK_W'(TABLE_SIZE - 1);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  in_t                in_data = '0;
  logic               in_stall;
  logic               out_valid;
  out_t               out_data;
  logic               out_stall = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [CFG_AW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the block table and the search start register
  logic [BLOCK_W-1:0] chain_link [TABLE_SIZE];
  bit                 block_used [TABLE_SIZE];
  logic [BLOCK_W-1:0] search_start;

  out_t pending_results [$];
  int   error_count = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   start_writes = 0;
  int   op_count [4];
  int   status_count [4];
  bit   quiet_tail = 1'b0;
  int   stall_left = 0;
  int   calm_left = 0;

  fat_chain_allocator_unit #(.BLOCK_COUNT(BLOCK_COUNT_DEF)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Load the formatted image into the shadow table
  task automatic load_formatted_image();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      chain_link[i] = '0;
      block_used[i] = (i < FORMAT_USED_CNT);
    end
    chain_link[FORMAT_LINK_BLK] = FORMAT_LINK_VAL;
    search_start = FIRST_DATA_RST;
  endtask

  function automatic bit block_live(logic [BLOCK_W-1:0] b);
    return (int'(b) < TABLE_SIZE) && block_used[b];
  endfunction

  // Lowest free block at or above the search start; zero start counts as one
  function automatic bit find_free_block(output logic [BLOCK_W-1:0] found);
    int i;
    found = '0;
    i = (search_start == '0) ? 1 : int'(search_start);
    while (i < TABLE_SIZE) begin
      if (!block_used[i]) begin
        found = BLOCK_W'(i);
        return 1'b1;
      end
      i++;
    end
    return 1'b0;
  endfunction

  // Apply one operation to the shadow table and return its result
  function automatic out_t apply_block_op(in_t item);
    out_t               r;
    logic [BLOCK_W-1:0] nb;
    logic [BLOCK_W-1:0] cur;
    logic [BLOCK_W-1:0] nx;
    r = '0;
    case (item.opcode)
      OP_ALLOC: begin
        if (find_free_block(nb)) begin
          block_used[nb] = 1'b1;
          chain_link[nb] = '0;
          r.result_block = nb;
        end else begin
          r.status = ST_NO_FREE;
        end
      end
      OP_EXTEND: begin
        if (!block_live(item.block)) begin
          r.status = ST_NOT_USED;
        end else if (find_free_block(nb)) begin
          chain_link[item.block] = nb;
          block_used[nb] = 1'b1;
          chain_link[nb] = '0;
          r.result_block = nb;
        end else begin
          r.status = ST_NO_FREE;
        end
      end
      OP_FREE: begin
        if (!block_live(item.block)) begin
          r.status = ST_NOT_USED;
        end else begin
          // Walk the chain, stopping at an end link or a block already released
          cur = item.block;
          for (int n = 0; n < TABLE_SIZE; n++) begin
            nx = chain_link[cur];
            block_used[cur] = 1'b0;
            chain_link[cur] = '0;
            if (nx == '0 || !block_live(nx)) break;
            cur = nx;
          end
        end
      end
      default: begin
        if (!block_live(item.block)) begin
          r.status = ST_NOT_USED;
        end else begin
          r.result_block = chain_link[item.block];
          r.end_of_chain = (chain_link[item.block] == '0);
        end
      end
    endcase
    return r;
  endfunction

  function automatic int count_used();
    int total;
    total = 0;
    for (int i = 0; i < TABLE_SIZE; i++) total += block_used[i];
    return total;
  endfunction

  function automatic logic [BLOCK_W-1:0] random_block();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return LAST_BLOCK;
    return BLOCK_W'($urandom);
  endfunction

  function automatic logic [BLOCK_W-1:0] pick_used_block();
    int total;
    int pick;
    total = count_used();
    if (total == 0) return random_block();
    pick = $urandom_range(0, total - 1);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (block_used[i]) begin
        if (pick == 0) return BLOCK_W'(i);
        pick--;
      end
    end
    return '0;
  endfunction

  // Present one item, hold it until transfer, then record its expected result
  task automatic send_item(input logic [1:0] op, input logic [BLOCK_W-1:0] blk);
    in_t item;
    int  gap;
    item.opcode = op;
    item.block  = blk;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, MAX_IDLE);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_block_op(item));
    items_sent++;
    op_count[op]++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write the search start register, then read it back
  task automatic write_first_data(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_FIRST_DATA;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    search_start = value[BLOCK_W-1:0];
    start_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[BLOCK_W-1:0] !== search_start) begin
      $display("%0t: first_data_block readback expected %0d got %0d",
               $realtime, search_start, prdata[BLOCK_W-1:0]);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
      error_count++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none got block %0d eoc %0d status %0d",
                 $realtime, out_data.result_block, out_data.end_of_chain, out_data.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_block", int'(want.result_block), int'(out_data.result_block));
        check_field("end_of_chain", int'(want.end_of_chain), int'(out_data.end_of_chain));
        check_field("status", int'(want.status), int'(out_data.status));
        status_count[want.status]++;
        results_seen++;
      end
    end
  end

  // Stall the result side in bursts, with calm stretches between
  always @(posedge clk) begin
    if (quiet_tail) begin
      stall_left = 0;
      calm_left  = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0 && $urandom_range(0, 3) == 0) calm_left = $urandom_range(30, 120);
    end else if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, MAX_IDLE);
    end
    out_stall <= (stall_left != 0);
  end

  // Formatted image: read the reserved chain and hit unused blocks
  task automatic test_formatted_image();
    send_item(OP_NEXT, BLOCK_W'(FORMAT_LINK_BLK));
    send_item(OP_NEXT, FORMAT_LINK_VAL);
    send_item(OP_NEXT, LAST_BLOCK);
    send_item(OP_EXTEND, LAST_BLOCK);
    send_item(OP_FREE, LAST_BLOCK);
    wait_drained();
  endtask

  // Build chains, overwrite a link, then free across a stale link
  task automatic test_chain_ops();
    logic [BLOCK_W-1:0] head;
    head = FIRST_DATA_RST;
    send_item(OP_ALLOC, LAST_BLOCK);
    send_item(OP_EXTEND, head);
    send_item(OP_EXTEND, head);
    send_item(OP_NEXT, head);
    send_item(OP_EXTEND, head + BLOCK_W'(2));
    send_item(OP_EXTEND, head + BLOCK_W'(3));
    send_item(OP_FREE, head + BLOCK_W'(2));
    send_item(OP_NEXT, head);
    send_item(OP_FREE, head);
    wait_drained();
  endtask

  // Start register at its extremes: full table, zero start, masked write
  task automatic test_start_register();
    write_first_data(32'(TABLE_SIZE - 4));
    repeat (4) send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, LAST_BLOCK);
    send_item(OP_EXTEND, BLOCK_W'(TABLE_SIZE - 4));
    wait_drained();
    write_first_data(32'd0);
    send_item(OP_FREE, BLOCK_W'(FORMAT_LINK_BLK));
    send_item(OP_ALLOC, '0);
    wait_drained();
    write_first_data(32'hFFFF_FFFF);
    send_item(OP_ALLOC, '0);
    wait_drained();
  endtask

  // Mostly well-formed traffic on live blocks, with some noise on random ones
  task automatic test_random_traffic(input logic [31:0] start, input int count,
                                     input bit pause_midway);
    logic [1:0]         op;
    logic [BLOCK_W-1:0] blk;
    int                 roll;
    write_first_data(start);
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (count_used() > 160 && $urandom_range(0, 1) == 1) op = OP_FREE;
      else if (roll < 30) op = OP_ALLOC;
      else if (roll < 55) op = OP_EXTEND;
      else if (roll < 75) op = OP_FREE;
      else op = OP_NEXT;
      if (op == OP_ALLOC || $urandom_range(0, 3) == 0) blk = random_block();
      else blk = pick_used_block();
      send_item(op, blk);
      // At the midpoint, when asked, hold off the sender until every result is back
      if (pause_midway && k == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    load_formatted_image();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_formatted_image();
    test_chain_ops();
    test_start_register();
    test_random_traffic(32'(FIRST_DATA_RST), 150, 1'b1);
    test_random_traffic(32'd1, 120, 1'b0);
    test_random_traffic(32'(TABLE_SIZE - 1), 40, 1'b0);
    test_random_traffic(32'($urandom_range(1, TABLE_SIZE - 1)), 120, 1'b1);
    quiet_tail = 1'b1;
    test_random_traffic(32'd2, 150, 1'b0);

    repeat (32) @(posedge clk);
    $display("Sent %0d items (alloc %0d, extend %0d, free %0d, next %0d), checked %0d results",
             items_sent, op_count[OP_ALLOC], op_count[OP_EXTEND], op_count[OP_FREE],
             op_count[OP_NEXT], results_seen);
    $display("Statuses: ok %0d, no free block %0d, block not in use %0d; %0d start writes",
             status_count[ST_OK], status_count[ST_NO_FREE], status_count[ST_NOT_USED],
             start_writes);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_fat_chain_allocator_unit passed");
    end else begin
      $display("tb_fat_chain_allocator_unit failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #20_000_000;
    $display("tb_fat_chain_allocator_unit failed");
    $finish;
  end

endmodule

[sim.f]
src/fca_pkg.sv
src/fca_ram.sv
src/fca_seq.sv
src/fat_chain_allocator_unit.sv
src/fca_checker.sv
bench/tb_fat_chain_allocator_unit.sv
